[rtl/core/sorted_two_way_merge_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sorted two-way merge block
// Next-cycle checks with and without the reset guard.
// ----------------------------------------------------------------------------
`ifndef SORTED_TWO_WAY_MERGE_TOP_MACROS_SVH
`define SORTED_TWO_WAY_MERGE_TOP_MACROS_SVH

// ante holds at an edge -> cons holds at the next edge, skipped in reset
`define STWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// same, but also checked while reset is high
`define STWM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/stwm_pkg.sv]
// ----------------------------------------------------------------------------
// stwm_pkg
// Types and constants shared by the sorted two-way merge block.
// ----------------------------------------------------------------------------
`default_nettype none

package stwm_pkg;

   localparam int DEPTH   = 32;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int OP_W    = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // input opcodes; the fourth code is unused
   typedef enum logic [OP_W-1:0] {
      OP_APPEND_A = 2'd0,
      OP_APPEND_B = 2'd1,
      OP_MERGE    = 2'd2
   } op_type;

   // command kinds held in the queue
   typedef enum logic [1:0] {
      CMD_APPEND_A = 2'd0,
      CMD_APPEND_B = 2'd1,
      CMD_MERGE    = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } back_state_type;

endpackage

`default_nettype wire

[rtl/core/stwm_if.sv]
// ----------------------------------------------------------------------------
// stwm request / response channels
// Valid/ready channels carrying input items and merged result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface stwm_req_if
   import stwm_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface stwm_rsp_if
   import stwm_pkg::*;
   ;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] merged_value;
   logic                      from_b;
   logic                      last;

   modport source (output valid, output merged_value, output from_b, output last,
                   input ready);
   modport sink   (input valid, input merged_value, input from_b, input last,
                   output ready);
endinterface

`default_nettype wire

[rtl/core/stwm_front.sv]
// ----------------------------------------------------------------------------
// stwm_front
// Takes input items, decodes the opcode, drops unused codes, feeds the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module stwm_front
   import stwm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   stwm_req_if.sink           req_ch,
   input  wire queue_status_type q_status,
   output logic               push,
   output cmd_type            push_cmd
);

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_cmd_ff, hold_cmd_in;
   logic    accept;
   logic    known_op;
   cmd_type dec_cmd;

   always_comb begin
      dec_cmd.value = req_ch.value;
      dec_cmd.kind  = CMD_MERGE;
      known_op      = 1'b1;
      case (op_type'(req_ch.op))
         OP_APPEND_A: dec_cmd.kind = CMD_APPEND_A;
         OP_APPEND_B: dec_cmd.kind = CMD_APPEND_B;
         OP_MERGE:    dec_cmd.kind = CMD_MERGE;
         default:     known_op     = 1'b0;
      endcase
   end

   assign push          = hold_valid_ff && !q_status.full;
   assign push_cmd      = hold_cmd_ff;
   assign req_ch.ready  = !hold_valid_ff || !q_status.full;
   assign accept        = req_ch.valid && req_ch.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_cmd_in   = hold_cmd_ff;
      if (push) begin
         hold_valid_in = 1'b0;
      end
      if (accept && known_op) begin
         hold_valid_in = 1'b1;
         hold_cmd_in   = dec_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_cmd_ff <= hold_cmd_in;
   end

endmodule

`default_nettype wire

[rtl/core/stwm_queue.sv]
// ----------------------------------------------------------------------------
// stwm_queue
// Small FIFO of decoded commands between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module stwm_queue
   import stwm_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire cmd_type      push_cmd,
   input  wire logic         pop,
   output queue_status_type  status,
   output cmd_type           head_cmd
);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_cmd     = slot_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[rtl/core/stwm_back.sv]
// ----------------------------------------------------------------------------
// stwm_back
// Holds both lists, runs appends and the merge, drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module stwm_back
   import stwm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire queue_status_type q_status,
   input  wire cmd_type       q_cmd,
   output logic               q_pop,
   stwm_rsp_if.source         rsp_ch
);

   logic signed [VALUE_W-1:0] mem_a [DEPTH];
   logic signed [VALUE_W-1:0] mem_b [DEPTH];
   logic signed [VALUE_W-1:0] head_a_ff, head_b_ff;

   back_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0] idx_a_ff, idx_a_in, idx_b_ff, idx_b_in;

   logic                      out_valid_ff, out_valid_in;
   logic signed [VALUE_W-1:0] out_value_ff, out_value_in;
   logic                      out_from_b_ff, out_from_b_in;
   logic                      out_last_ff, out_last_in;

   logic             wr_a, wr_b;
   logic             out_free, a_left, b_left, take_a, last_hit;
   logic [CNT_W:0]   emitted_sum, total_sum;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign a_left   = idx_a_ff < cnt_a_ff;
   assign b_left   = idx_b_ff < cnt_b_ff;
   // ties go to list A
   assign take_a   = a_left && (!b_left || (head_a_ff <= head_b_ff));

   assign emitted_sum = {1'b0, idx_a_ff} + {1'b0, idx_b_ff} + (CNT_W+1)'(1);
   assign total_sum   = {1'b0, cnt_a_ff} + {1'b0, cnt_b_ff};
   assign last_hit    = (emitted_sum == total_sum);

   always_comb begin
      state_in      = state_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      idx_a_in      = idx_a_ff;
      idx_b_in      = idx_b_ff;
      q_pop         = 1'b0;
      wr_a          = 1'b0;
      wr_b          = 1'b0;
      out_valid_in  = out_valid_ff && !rsp_ch.ready;
      out_value_in  = out_value_ff;
      out_from_b_in = out_from_b_ff;
      out_last_in   = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_status.valid) begin
               q_pop = 1'b1;
               case (q_cmd.kind)
                  CMD_APPEND_A: begin
                     if (cnt_a_ff != CNT_W'(DEPTH)) begin
                        wr_a     = 1'b1;
                        cnt_a_in = cnt_a_ff + CNT_W'(1);
                     end
                  end
                  CMD_APPEND_B: begin
                     if (cnt_b_ff != CNT_W'(DEPTH)) begin
                        wr_b     = 1'b1;
                        cnt_b_in = cnt_b_ff + CNT_W'(1);
                     end
                  end
                  CMD_MERGE: begin
                     // the pop cycle also loads both heads from entry zero
                     if (cnt_a_ff != '0 || cnt_b_ff != '0) begin
                        state_in = ST_RUN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_value_in  = take_a ? head_a_ff : head_b_ff;
               out_from_b_in = !take_a;
               out_last_in   = last_hit;
               if (take_a) begin
                  idx_a_in = idx_a_ff + CNT_W'(1);
               end else begin
                  idx_b_in = idx_b_ff + CNT_W'(1);
               end
               if (last_hit) begin
                  idx_a_in = '0;
                  idx_b_in = '0;
                  cnt_a_in = '0;
                  cnt_b_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_a_ff     <= '0;
         cnt_b_ff     <= '0;
         idx_a_ff     <= '0;
         idx_b_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_a_ff     <= cnt_a_in;
         cnt_b_ff     <= cnt_b_in;
         idx_a_ff     <= idx_a_in;
         idx_b_ff     <= idx_b_in;
         out_valid_ff <= out_valid_in;
      end
      out_value_ff  <= out_value_in;
      out_from_b_ff <= out_from_b_in;
      out_last_ff   <= out_last_in;
   end

   // list storage: one write port, one registered read port per list
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[cnt_a_ff[IDX_W-1:0]] <= q_cmd.value;
      end
      head_a_ff <= mem_a[idx_a_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[cnt_b_ff[IDX_W-1:0]] <= q_cmd.value;
      end
      head_b_ff <= mem_b[idx_b_in[IDX_W-1:0]];
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.merged_value = out_value_ff;
   assign rsp_ch.from_b       = out_from_b_ff;
   assign rsp_ch.last         = out_last_ff;

endmodule

`default_nettype wire

[rtl/core/sorted_two_way_merge_top.sv]
// Path: front register -> queue slot -> back, where an append is written; a
//   merge then passes the head and result registers before its first result.
// Throughput: one input item per cycle while the queue has room; a merge holds
//   the back for count_a + count_b results, one per cycle the sink is ready.
// Reset (synchronous, active high) empties both lists, the queue and the
//   result register; list storage itself is not cleared.
// ----------------------------------------------------------------------------
// sorted_two_way_merge_top
// Two-way merge of two sorted lists of signed 32-bit values.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_two_way_merge_top
   import stwm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   stwm_req_if.sink     req_ch,
   stwm_rsp_if.source   rsp_ch
);

   // Front: registers each item, decodes the op, drops the unused op code.
   // Queue: two commands deep, so loads wait in it while a merge drains.
   // Back: the two list memories, their counts, and the merge engine.
   //   Each list memory has a registered read port that always reads the
   //   entry at the list's next index, so the register holds the list head.
   //   The head register is primed in the cycle the merge command is popped.

   queue_status_type q_status;
   logic             push;
   cmd_type          push_cmd;
   logic             q_pop;
   cmd_type          q_cmd;

   stwm_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   stwm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .status   (q_status),
      .head_cmd (q_cmd)
   );

   // one result per cycle while the sink keeps ready high; last marks the
   // final item of each merge
   stwm_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .q_cmd    (q_cmd),
      .q_pop    (q_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

[rtl/core/stwm_checker.sv]
// ----------------------------------------------------------------------------
// stwm_checker
// Port-level checks on the merge block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_two_way_merge_top_macros.svh"

module stwm_checker
   import stwm_pkg::*;
(
   input wire logic                      clock,
   input wire logic                      reset,
   input wire logic                      req_ready,
   input wire logic                      rsp_valid,
   input wire logic                      rsp_ready,
   input wire logic signed [VALUE_W-1:0] rsp_merged_value,
   input wire logic                      rsp_from_b,
   input wire logic                      rsp_last
);

   logic               rsp_stall;
   logic [VALUE_W+1:0] rsp_payload;

   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_merged_value, rsp_from_b, rsp_last};

   `STWM_ASSERT_NEXT_ALWAYS(a_reset_no_rsp, clock, reset, !rsp_valid, "result after reset")
   `STWM_ASSERT_NEXT_ALWAYS(a_reset_ready, clock, reset, req_ready, "not ready after reset")
   `STWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid, "valid drop")
   `STWM_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_payload), "payload moved")

endmodule

bind sorted_two_way_merge_top stwm_checker u_stwm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_merged_value (rsp_ch.merged_value),
   .rsp_from_b       (rsp_ch.from_b),
   .rsp_last         (rsp_ch.last)
);

`default_nettype wire
